FILE: rtl/cmfs_pkg.sv
// ----------------------------------------------------------------------------
// cmfs_pkg
// Shared types, constants and helpers for the cube map face select core.
// ----------------------------------------------------------------------------
package cmfs_pkg;

    localparam int DIR_W           = 16;
    localparam int SIZE_W          = 13;
    localparam int SPAN_W          = 13;
    localparam int SUM_W           = DIR_W + 1;
    localparam int DEN_W           = DIR_W + 1;
    localparam int PROD_W          = SPAN_W + SUM_W;
    localparam int COORD_FRAC_BITS = 8;
    localparam int QUO_W           = SPAN_W + COORD_FRAC_BITS;
    localparam int DIV_STAGES      = QUO_W;
    localparam int COORD_W         = 20;
    localparam int FACE_W          = 3;
    localparam int POS_W           = QUO_W + 1;

    localparam logic [SIZE_W-1:0]  SIZE_RESET = SIZE_W'(1024);
    localparam logic [POS_W-1:0]   POS_ONE    = POS_W'(1) << COORD_FRAC_BITS;
    localparam logic [POS_W-1:0]   POS_MAX    = POS_W'((64'd1 << COORD_W) - 64'd1);

    typedef enum logic [FACE_W-1:0] {
        FACE_PX = 3'd0,
        FACE_NX = 3'd1,
        FACE_PY = 3'd2,
        FACE_NY = 3'd3,
        FACE_PZ = 3'd4,
        FACE_NZ = 3'd5
    } t_face;

    typedef enum logic [0:0] {
        REG_FACE_HEIGHT = 1'b0,
        REG_FACE_WIDTH  = 1'b1
    } t_cfg_reg;

    // partial remainder and the word that holds numerator bits still to come
    // in its top and quotient bits already found in its bottom
    typedef struct packed {
        logic [DEN_W-1:0] rem;
        logic [QUO_W-1:0] nq;
    } t_div_lane;

    function automatic logic [SPAN_W-1:0] span_of(input logic [SIZE_W-1:0] size);
        logic [SIZE_W-1:0] s;
        s = (size > SIZE_W'(2)) ? (size - SIZE_W'(2)) : '0;
        return s[SPAN_W-1:0];
    endfunction

    function automatic t_div_lane div_step(input t_div_lane d,
                                           input logic [DEN_W-1:0] den);
        logic [DEN_W:0] t;
        t_div_lane      r;
        t    = {d.rem, d.nq[QUO_W-1]};
        r.nq = {d.nq[QUO_W-2:0], 1'b0};
        if (t >= {1'b0, den}) begin
            t       = t - {1'b0, den};
            r.nq[0] = 1'b1;
        end
        r.rem = t[DEN_W-1:0];
        return r;
    endfunction

endpackage

FILE: rtl/cube_map_face_select_core.sv
// ----------------------------------------------------------------------------
// cube_map_face_select_core
// Picks the cube face of a direction vector and its row/column position.
// ----------------------------------------------------------------------------
//  channel   | signals                                  | direction
//  ----------+------------------------------------------+----------
//  input     | i_valid, o_stall, i_dir_x/y/z            | in
//  result    | o_valid, i_stall, o_face_index,          | out
//            | o_row_coord, o_col_coord, o_hit_valid    |
//  config    | i_cfg_valid, o_cfg_ready, i_cfg_index,   | in
//            | i_cfg_data                               |
//
//  One item per cycle while the output is not stalled; registered steps in order: face select,
//  span multiply, 21 restoring divide stages (one quotient bit each), add and saturate.
//  A stalled full output register holds the whole pipeline in place.
//  Reset clears the valid bits and sets both face sizes to 1024.
// ----------------------------------------------------------------------------
module cube_map_face_select_core (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic signed [cmfs_pkg::DIR_W-1:0] i_dir_x,
    input  logic signed [cmfs_pkg::DIR_W-1:0] i_dir_y,
    input  logic signed [cmfs_pkg::DIR_W-1:0] i_dir_z,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [cmfs_pkg::FACE_W-1:0]  o_face_index,
    output logic [cmfs_pkg::COORD_W-1:0] o_row_coord,
    output logic [cmfs_pkg::COORD_W-1:0] o_col_coord,
    output logic                         o_hit_valid,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [0:0]                   i_cfg_index,
    input  logic [cmfs_pkg::SIZE_W-1:0]  i_cfg_data
);

    localparam int DW = cmfs_pkg::DIR_W;
    localparam int NS = cmfs_pkg::DIV_STAGES;

    logic en;

    logic [cmfs_pkg::SIZE_W-1:0] r_face_height;
    logic [cmfs_pkg::SIZE_W-1:0] r_face_width;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_face_height <= cmfs_pkg::SIZE_RESET;
            r_face_width  <= cmfs_pkg::SIZE_RESET;
        end else if (i_cfg_valid) begin
            unique case (cmfs_pkg::t_cfg_reg'(i_cfg_index))
                cmfs_pkg::REG_FACE_HEIGHT: r_face_height <= i_cfg_data;
                cmfs_pkg::REG_FACE_WIDTH:  r_face_width  <= i_cfg_data;
            endcase
        end
    end

    // hold everything while the output register is full and stalled
    assign en      = !(o_valid && i_stall);
    assign o_stall = o_valid && i_stall;

    // ---------------- stage A: face select ----------------
    logic signed [DW:0] sx, sy, sz, nx, ny, nz;
    logic [DW-1:0]      ax, ay, az;
    logic               xm, ym, zm;
    cmfs_pkg::t_face    n_a_face;
    logic               n_a_hit;
    logic [DW-1:0]      n_a_major;
    logic signed [DW:0] n_a_rmin, n_a_cmin;

    always_comb begin
        sx = {i_dir_x[DW-1], i_dir_x};
        sy = {i_dir_y[DW-1], i_dir_y};
        sz = {i_dir_z[DW-1], i_dir_z};
        nx = -sx;
        ny = -sy;
        nz = -sz;
        ax = sx[DW] ? nx[DW-1:0] : sx[DW-1:0];
        ay = sy[DW] ? ny[DW-1:0] : sy[DW-1:0];
        az = sz[DW] ? nz[DW-1:0] : sz[DW-1:0];
        xm = (ax >= ay) && (ax >= az);
        ym = (ay >= ax) && (ay >= az);
        zm = (az >= ax) && (az >= ay);
        n_a_face  = cmfs_pkg::FACE_PX;
        n_a_hit   = 1'b1;
        n_a_major = ax;
        n_a_cmin  = nz;
        n_a_rmin  = ny;
        priority if (!sx[DW] && (sx != '0) && xm) begin
            n_a_face = cmfs_pkg::FACE_PX; n_a_major = ax; n_a_cmin = nz; n_a_rmin = ny;
        end else if (sx[DW] && xm) begin
            n_a_face = cmfs_pkg::FACE_NX; n_a_major = ax; n_a_cmin = sz; n_a_rmin = ny;
        end else if (!sy[DW] && (sy != '0) && ym) begin
            n_a_face = cmfs_pkg::FACE_PY; n_a_major = ay; n_a_cmin = sx; n_a_rmin = sz;
        end else if (sy[DW] && ym) begin
            n_a_face = cmfs_pkg::FACE_NY; n_a_major = ay; n_a_cmin = sx; n_a_rmin = nz;
        end else if (!sz[DW] && (sz != '0) && zm) begin
            n_a_face = cmfs_pkg::FACE_PZ; n_a_major = az; n_a_cmin = sx; n_a_rmin = ny;
        end else if (sz[DW] && zm) begin
            n_a_face = cmfs_pkg::FACE_NZ; n_a_major = az; n_a_cmin = nx; n_a_rmin = ny;
        end else begin
            // zero vector: keep the divisor non-zero, result is forced to zero
            n_a_face  = cmfs_pkg::FACE_PX;
            n_a_hit   = 1'b0;
            n_a_major = DW'(1);
            n_a_cmin  = '0;
            n_a_rmin  = '0;
        end
    end

    logic               r_a_valid;
    cmfs_pkg::t_face    r_a_face;
    logic               r_a_hit;
    logic [DW-1:0]      r_a_major;
    logic signed [DW:0] r_a_rmin, r_a_cmin;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (en) begin
            r_a_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_face  <= n_a_face;
            r_a_hit   <= n_a_hit;
            r_a_major <= n_a_major;
            r_a_rmin  <= n_a_rmin;
            r_a_cmin  <= n_a_cmin;
        end
    end

    // ---------------- stage B: span * (minor + major) ----------------
    logic signed [DW+1:0]          rsum_s, csum_s;
    logic [cmfs_pkg::SUM_W-1:0]    rsum, csum;
    logic [cmfs_pkg::PROD_W-1:0]   n_b_rprod, n_b_cprod;

    always_comb begin
        rsum_s    = {r_a_rmin[DW], r_a_rmin} + $signed({2'b00, r_a_major});
        csum_s    = {r_a_cmin[DW], r_a_cmin} + $signed({2'b00, r_a_major});
        rsum      = rsum_s[cmfs_pkg::SUM_W-1:0];
        csum      = csum_s[cmfs_pkg::SUM_W-1:0];
        n_b_rprod = cmfs_pkg::PROD_W'(cmfs_pkg::span_of(r_face_height))
                  * cmfs_pkg::PROD_W'(rsum);
        n_b_cprod = cmfs_pkg::PROD_W'(cmfs_pkg::span_of(r_face_width))
                  * cmfs_pkg::PROD_W'(csum);
    end

    logic                          r_b_valid;
    cmfs_pkg::t_face               r_b_face;
    logic                          r_b_hit;
    logic [cmfs_pkg::DEN_W-1:0]    r_b_den;
    logic [cmfs_pkg::PROD_W-1:0]   r_b_rprod, r_b_cprod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (en) begin
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_b_face  <= r_a_face;
            r_b_hit   <= r_a_hit;
            r_b_den   <= {r_a_major, 1'b0};
            r_b_rprod <= n_b_rprod;
            r_b_cprod <= n_b_cprod;
        end
    end

    // ---------------- divide stages: one quotient bit each ----------------
    // numerator is prod scaled by the coordinate fraction; its top bits are
    // already below the divisor, so they seed the partial remainder
    localparam int NUM_W = cmfs_pkg::PROD_W + cmfs_pkg::COORD_FRAC_BITS;

    logic [NUM_W-1:0]    rnum, cnum;
    cmfs_pkg::t_div_lane n_d0_r, n_d0_c;

    always_comb begin
        rnum   = {r_b_rprod, cmfs_pkg::COORD_FRAC_BITS'(0)};
        cnum   = {r_b_cprod, cmfs_pkg::COORD_FRAC_BITS'(0)};
        n_d0_r = cmfs_pkg::div_step({rnum[NUM_W-1 -: cmfs_pkg::DEN_W],
                                     rnum[cmfs_pkg::QUO_W-1:0]}, r_b_den);
        n_d0_c = cmfs_pkg::div_step({cnum[NUM_W-1 -: cmfs_pkg::DEN_W],
                                     cnum[cmfs_pkg::QUO_W-1:0]}, r_b_den);
    end

    logic                       r_d_valid [NS];
    cmfs_pkg::t_face            r_d_face  [NS];
    logic                       r_d_hit   [NS];
    logic [cmfs_pkg::DEN_W-1:0] r_d_den   [NS];
    cmfs_pkg::t_div_lane        r_d_row   [NS];
    cmfs_pkg::t_div_lane        r_d_col   [NS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NS; k++) begin
                r_d_valid[k] <= 1'b0;
            end
        end else if (en) begin
            r_d_valid[0] <= r_b_valid;
            for (int k = 1; k < NS; k++) begin
                r_d_valid[k] <= r_d_valid[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_d_face[0] <= r_b_face;
            r_d_hit[0]  <= r_b_hit;
            r_d_den[0]  <= r_b_den;
            r_d_row[0]  <= n_d0_r;
            r_d_col[0]  <= n_d0_c;
            for (int k = 1; k < NS; k++) begin
                r_d_face[k] <= r_d_face[k-1];
                r_d_hit[k]  <= r_d_hit[k-1];
                r_d_den[k]  <= r_d_den[k-1];
                r_d_row[k]  <= cmfs_pkg::div_step(r_d_row[k-1], r_d_den[k-1]);
                r_d_col[k]  <= cmfs_pkg::div_step(r_d_col[k-1], r_d_den[k-1]);
            end
        end
    end

    // ---------------- output stage: offset by one, saturate ----------------
    logic [cmfs_pkg::POS_W-1:0]   rpos, cpos;
    logic [cmfs_pkg::COORD_W-1:0] n_o_row, n_o_col;

    always_comb begin
        rpos = cmfs_pkg::POS_ONE + {1'b0, r_d_row[NS-1].nq};
        cpos = cmfs_pkg::POS_ONE + {1'b0, r_d_col[NS-1].nq};
        n_o_row = (rpos > cmfs_pkg::POS_MAX) ? cmfs_pkg::POS_MAX[cmfs_pkg::COORD_W-1:0]
                                             : rpos[cmfs_pkg::COORD_W-1:0];
        n_o_col = (cpos > cmfs_pkg::POS_MAX) ? cmfs_pkg::POS_MAX[cmfs_pkg::COORD_W-1:0]
                                             : cpos[cmfs_pkg::COORD_W-1:0];
        if (!r_d_hit[NS-1]) begin
            n_o_row = '0;
            n_o_col = '0;
        end
    end

    logic                         r_o_valid;
    logic [cmfs_pkg::FACE_W-1:0]  r_o_face;
    logic [cmfs_pkg::COORD_W-1:0] r_o_row, r_o_col;
    logic                         r_o_hit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (en) begin
            r_o_valid <= r_d_valid[NS-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_o_face <= r_d_hit[NS-1] ? r_d_face[NS-1] : cmfs_pkg::FACE_PX;
            r_o_hit  <= r_d_hit[NS-1];
            r_o_row  <= n_o_row;
            r_o_col  <= n_o_col;
        end
    end

    assign o_valid      = r_o_valid;
    assign o_face_index = r_o_face;
    assign o_row_coord  = r_o_row;
    assign o_col_coord  = r_o_col;
    assign o_hit_valid  = r_o_hit;

endmodule

FILE: sim/cube_map_face_select_core_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cube_map_face_select_core_test
// Self-checking bench for the cube map face select core: directed and random
// direction vectors under several face sizes and idling phases, each result
// compared with a behavioural face/position calculation.
// ----------------------------------------------------------------------------
module cube_map_face_select_core_test;

    typedef struct {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
    } t_dir;

    typedef struct {
        logic [2:0]  face;
        logic [19:0] row;
        logic [19:0] col;
        logic        hit;
    } t_hit;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic signed [15:0] i_dir_x, i_dir_y, i_dir_z;
    logic        o_valid;
    logic        i_stall;
    logic [2:0]  o_face_index;
    logic [19:0] o_row_coord, o_col_coord;
    logic        o_hit_valid;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [0:0]  i_cfg_index;
    logic [12:0] i_cfg_data;

    t_dir   dir_queue[$];
    t_hit   hit_queue[$];
    logic [12:0] height_cfg, width_cfg;
    int     send_idle_pct, recv_stall_pct;
    int     mismatches, hits_seen, vectors_sent;

    cube_map_face_select_core dut (.*);

    always begin
        i_clk = 1'b1; #2;
        i_clk = 1'b0; #2;
    end

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch on %s: got %0d expected %0d", what, got, want);
        mismatches++;
    endtask

    function automatic logic [19:0] face_pos(input longint minor, input longint major,
                                             input logic [12:0] size);
        longint span, pos;
        span = (size > 2) ? size - 2 : 0;
        pos = 256 + (span * (minor + major) * 256) / (2 * major);
        return (pos > 1048575) ? 20'hFFFFF : pos[19:0];
    endfunction

    function automatic t_hit select_face(input t_dir d);
        longint x, y, z, ax, ay, az, major, cmin, rmin;
        bit xm, ym, zm;
        t_hit r;
        x = d.x; y = d.y; z = d.z;
        ax = x < 0 ? -x : x; ay = y < 0 ? -y : y; az = z < 0 ? -z : z;
        xm = ax >= ay && ax >= az;
        ym = ay >= ax && ay >= az;
        zm = az >= ax && az >= ay;
        r = '{3'd0, 20'd0, 20'd0, 1'b0};
        if (x > 0 && xm) begin
            r.face = cmfs_pkg::FACE_PX; major = ax; cmin = -z; rmin = -y;
        end else if (x < 0 && xm) begin
            r.face = cmfs_pkg::FACE_NX; major = ax; cmin = z; rmin = -y;
        end else if (y > 0 && ym) begin
            r.face = cmfs_pkg::FACE_PY; major = ay; cmin = x; rmin = z;
        end else if (y < 0 && ym) begin
            r.face = cmfs_pkg::FACE_NY; major = ay; cmin = x; rmin = -z;
        end else if (z > 0 && zm) begin
            r.face = cmfs_pkg::FACE_PZ; major = az; cmin = x; rmin = -y;
        end else if (z < 0 && zm) begin
            r.face = cmfs_pkg::FACE_NZ; major = az; cmin = -x; rmin = -y;
        end else begin
            return r;
        end
        r.hit = 1'b1;
        r.row = face_pos(rmin, major, height_cfg);
        r.col = face_pos(cmin, major, width_cfg);
        return r;
    endfunction

    // driver: present the head of the queue, advance on acceptance
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                hit_queue = {hit_queue, select_face('{i_dir_x, i_dir_y, i_dir_z})};
                void'(dir_queue.pop_front());
                vectors_sent++;
            end
            if (!(i_valid && o_stall)) begin
                if (dir_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    i_valid <= 1'b1;
                    i_dir_x <= dir_queue[0].x;
                    i_dir_y <= dir_queue[0].y;
                    i_dir_z <= dir_queue[0].z;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_hit want;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                if (hit_queue.size() == 0) begin
                    report_mismatch("unexpected result", o_face_index, -1);
                end else begin
                    want = hit_queue.pop_front();
                    hits_seen++;
                    if (o_hit_valid !== want.hit)
                        report_mismatch("hit_valid", o_hit_valid, want.hit);
                    if (o_face_index !== want.face)
                        report_mismatch("face_index", o_face_index, want.face);
                    if (o_row_coord !== want.row)
                        report_mismatch("row_coord", o_row_coord, want.row);
                    if (o_col_coord !== want.col)
                        report_mismatch("col_coord", o_col_coord, want.col);
                end
            end
            i_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    task automatic write_reg(input cmfs_pkg::t_cfg_reg idx, input logic [12:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == cmfs_pkg::REG_FACE_HEIGHT) height_cfg = val; else width_cfg = val;
    endtask

    task automatic drain;
        while (dir_queue.size() != 0 || i_valid || hit_queue.size() != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
    endtask

    task automatic queue_dir(input logic signed [15:0] x, input logic signed [15:0] y,
                             input logic signed [15:0] z);
        t_dir d;
        d.x = x; d.y = y; d.z = z;
        dir_queue = {dir_queue, d};
    endtask

    function automatic logic signed [15:0] rand_comp(input int mode);
        case (mode)
            0: return 16'($urandom);
            1: return 16'($signed($urandom_range(32768)) - 16384);
            default: return 16'($signed($urandom_range(8)) - 4);
        endcase
    endfunction

    task automatic push_random(input int n);
        t_dir d;
        int mode;
        repeat (n) begin
            mode = $urandom_range(9);
            mode = mode < 2 ? 0 : (mode < 9 ? 1 : 2);
            d.x = rand_comp(mode); d.y = rand_comp(mode); d.z = rand_comp(mode);
            if ($urandom_range(9) == 0) d.y = d.x;
            dir_queue = {dir_queue, d};
        end
    endtask

    initial begin
        logic [12:0] sizes[5];
        i_rst_n = 1'b0; i_valid = 1'b0; i_stall = 1'b0;
        i_dir_x = '0; i_dir_y = '0; i_dir_z = '0;
        i_cfg_valid = 1'b0; i_cfg_index = cmfs_pkg::REG_FACE_HEIGHT; i_cfg_data = '0;
        send_idle_pct = 0; recv_stall_pct = 0;
        mismatches = 0; hits_seen = 0; vectors_sent = 0;
        height_cfg = cmfs_pkg::SIZE_RESET; width_cfg = cmfs_pkg::SIZE_RESET;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: each face, ties, zero vector, full scale
        foreach (sizes[k]) sizes[k] = '0;
        queue_dir(16'sd16384, 16'sd0, 16'sd0);
        queue_dir(-16'sd16384, 16'sd0, 16'sd0);
        queue_dir(16'sd0, 16'sd16384, 16'sd0);
        queue_dir(16'sd0, -16'sd16384, 16'sd0);
        queue_dir(16'sd0, 16'sd0, 16'sd16384);
        queue_dir(16'sd0, 16'sd0, -16'sd16384);
        queue_dir(16'sd0, 16'sd0, 16'sd0);
        queue_dir(16'sd100, 16'sd100, 16'sd100);
        queue_dir(-16'sd100, -16'sd100, -16'sd100);
        queue_dir(-16'sd50, 16'sd50, 16'sd50);
        queue_dir(16'sd0, -16'sd7, 16'sd7);
        queue_dir(16'h8000, 16'h7FFF, 16'h8000);
        queue_dir(16'h7FFF, 16'h8000, 16'h7FFF);
        queue_dir(16'h8000, 16'h8000, 16'h8000);
        queue_dir(16'sd1, 16'sd0, 16'sd0);
        queue_dir(16'sd16384, -16'sd16384, 16'sd16383);
        queue_dir(16'h5555, 16'hAAAA, 16'h1234);
        drain();

        sizes = '{13'd3, 13'd4096, 13'd8191, 13'd0, 13'd1};
        for (int p = 0; p < 8; p++) begin
            write_reg(cmfs_pkg::REG_FACE_HEIGHT,
                      p < 5 ? sizes[p] : 13'($urandom_range(3, 4096)));
            write_reg(cmfs_pkg::REG_FACE_WIDTH,
                      p < 5 ? sizes[4 - p] : 13'($urandom_range(3, 4096)));
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 50; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 50; end
                default: begin send_idle_pct = 31; recv_stall_pct = 31; end
            endcase
            push_random(75);
            drain();
        end

        $display("covered %0d vectors and %0d results", vectors_sent, hits_seen);
        $display("over eight face size settings and four idling phases");
        if (mismatches == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("TEST FAILED");
        $finish;
    end
endmodule

FILE: sim.f
rtl/cmfs_pkg.sv
rtl/cube_map_face_select_core.sv
sim/cube_map_face_select_core_test.sv
